// ===== rtl/core/ts_pkg.sv =====
// ----------------------------------------------------------------------------
// ts_pkg
// shared constants and types for the ternary search table
// ----------------------------------------------------------------------------
`default_nettype none

package ts_pkg;

  localparam int TS_DEPTH = 1024;
  localparam int TS_IDX_W = 10;
  localparam int TS_VAL_W = 32;
  localparam int TS_BND_W = TS_IDX_W + 2;

  // floor(x / 3) == (x * 683) >> 11 for every x below 2048
  localparam int          TS_RECIP_W     = 11;
  localparam int          TS_RECIP_SHIFT = 11;
  localparam logic [10:0] TS_RECIP       = 11'd683;

  typedef enum logic {
    CMD_WRITE  = 1'b0,
    CMD_SEARCH = 1'b1
  } cmd_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SPAN,
    ST_RD1,
    ST_RD2,
    ST_CMP,
    ST_DONE
  } state_t;

endpackage

`default_nettype wire

// ===== rtl/core/ternary_search_table.sv =====
// ----------------------------------------------------------------------------
// ternary_search_table
// ternary search over a ram table of signed 32-bit entries
// ----------------------------------------------------------------------------
// input beats carry a command: cmd = write stores entry_value at entry_index
// (an index beyond the table is dropped), cmd = search looks for search_key
// in the inclusive range low_index..high_index, with high_index clamped to
// the last table entry. a write gives no result beat; a search gives one
// result beat with found and position (position is 0 when not found).
// a write is stored on accept. a search runs in rounds until a hit or an empty
// range and then shows its result beat, where a round
// probes two points a third in from each end and narrows the range; a 1024
// entry range needs at most about seven rounds.
// each round passes the span state, which finds the span and divides it by three (one
// small multiply by the reciprocal), then two read states for the two reads through the
// single ram read port and a compare state. in_ready is high only while idle.
// the result sits in an output register; a stalled receiver holds the block
// in its final state until the previous beat is taken. reset clears the sequencer and
// the output valid; table contents are undefined until written.
// ----------------------------------------------------------------------------
`default_nettype none

module ternary_search_table (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         in_valid,
  output logic                              in_ready,
  input  wire logic                         in_cmd,
  input  wire logic [ts_pkg::TS_IDX_W-1:0]  in_entry_index,
  input  wire logic signed [ts_pkg::TS_VAL_W-1:0] in_entry_value,
  input  wire logic signed [ts_pkg::TS_VAL_W-1:0] in_search_key,
  input  wire logic [ts_pkg::TS_IDX_W-1:0]  in_low_index,
  input  wire logic [ts_pkg::TS_IDX_W-1:0]  in_high_index,
  output logic                              out_valid,
  input  wire logic                         out_ready,
  output logic                              out_found,
  output logic [ts_pkg::TS_IDX_W-1:0]       out_position
);

  import ts_pkg::*;

  localparam logic [TS_IDX_W:0] LAST = (TS_IDX_W + 1)'(TS_DEPTH - 1);
  localparam int                PROD_W = TS_IDX_W + TS_RECIP_W;

  state_t state_r, state_nxt;

  logic                       out_valid_r, out_valid_nxt;
  logic                       out_found_r, out_found_nxt;
  logic [TS_IDX_W-1:0]        out_position_r, out_position_nxt;

  logic signed [TS_VAL_W-1:0] key_r, key_nxt;
  logic signed [TS_VAL_W-1:0] v1_r, v1_nxt;
  logic signed [TS_BND_W-1:0] lo_r, lo_nxt;
  logic signed [TS_BND_W-1:0] hi_r, hi_nxt;
  logic [TS_IDX_W-1:0]        third_r, third_nxt;
  logic [TS_IDX_W-1:0]        p1_r, p1_nxt;
  logic [TS_IDX_W-1:0]        p2_r, p2_nxt;
  logic                       res_found_r, res_found_nxt;
  logic [TS_IDX_W-1:0]        res_pos_r, res_pos_nxt;

  logic                       wr_en;
  logic [TS_IDX_W-1:0]        rd_addr;
  logic [TS_VAL_W-1:0]        rd_data;
  logic signed [TS_VAL_W-1:0] v2;
  logic                       accept;
  logic                       out_free;
  logic                       empty;
  logic                       match1;
  logic                       match2;
  logic [TS_IDX_W-1:0]        hi_clamped;
  logic [TS_BND_W-1:0]        span_full;
  logic [PROD_W-1:0]          prod;

  assign accept     = in_valid && in_ready;
  assign out_free   = !out_valid_r || out_ready;
  assign empty      = hi_r < lo_r;
  assign v2         = $signed(rd_data);
  assign match1     = v1_r == key_r;
  assign match2     = v2 == key_r;
  assign hi_clamped = ({1'b0, in_high_index} > LAST) ? LAST[TS_IDX_W-1:0] : in_high_index;
  assign span_full  = hi_r - lo_r;
  assign prod       = span_full[TS_IDX_W-1:0] * TS_RECIP;

  assign wr_en = accept && (cmd_t'(in_cmd) == CMD_WRITE) &&
                 ({1'b0, in_entry_index} <= LAST);

  ts_ram #(
    .WIDTH (TS_VAL_W),
    .DEPTH (TS_DEPTH)
  ) u_table (
    .clk   (clk),
    .we    (wr_en),
    .waddr (in_entry_index),
    .wdata (in_entry_value),
    .raddr (rd_addr),
    .rdata (rd_data)
  );

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (accept && (cmd_t'(in_cmd) == CMD_SEARCH)) begin
          state_nxt = ST_SPAN;
        end
      end
      ST_SPAN: begin
        state_nxt = empty ? ST_DONE : ST_RD1;
      end
      ST_RD1: state_nxt = ST_RD2;
      ST_RD2: state_nxt = ST_CMP;
      ST_CMP: begin
        state_nxt = (match1 || match2) ? ST_DONE : ST_SPAN;
      end
      ST_DONE: begin
        if (out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // outputs of the sequencer
  always_comb begin
    in_ready = 1'b0;
    rd_addr  = '0;
    unique case (state_r)
      ST_IDLE: in_ready = 1'b1;
      ST_RD1:  rd_addr  = lo_r[TS_IDX_W-1:0] + third_r;
      ST_RD2:  rd_addr  = p2_r;
      default: rd_addr  = '0;
    endcase
  end

  // datapath
  always_comb begin
    key_nxt          = key_r;
    v1_nxt           = v1_r;
    lo_nxt           = lo_r;
    hi_nxt           = hi_r;
    third_nxt        = third_r;
    p1_nxt           = p1_r;
    p2_nxt           = p2_r;
    res_found_nxt    = res_found_r;
    res_pos_nxt      = res_pos_r;
    out_valid_nxt    = out_valid_r && !out_ready;
    out_found_nxt    = out_found_r;
    out_position_nxt = out_position_r;
    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          key_nxt = in_search_key;
          lo_nxt  = $signed({2'b00, in_low_index});
          hi_nxt  = $signed({2'b00, hi_clamped});
        end
      end
      ST_SPAN: begin
        third_nxt = prod[TS_RECIP_SHIFT +: TS_IDX_W];
        if (empty) begin
          res_found_nxt = 1'b0;
          res_pos_nxt   = '0;
        end
      end
      ST_RD1: begin
        p1_nxt = lo_r[TS_IDX_W-1:0] + third_r;
        p2_nxt = hi_r[TS_IDX_W-1:0] - third_r;
      end
      ST_RD2: begin
        v1_nxt = $signed(rd_data);
      end
      ST_CMP: begin
        priority if (match1) begin
          res_found_nxt = 1'b1;
          res_pos_nxt   = p1_r;
        end else if (match2) begin
          res_found_nxt = 1'b1;
          res_pos_nxt   = p2_r;
        end else if (key_r < v1_r) begin
          hi_nxt = $signed({2'b00, p1_r}) - TS_BND_W'(1);
        end else if (key_r > v2) begin
          lo_nxt = $signed({2'b00, p2_r}) + TS_BND_W'(1);
        end else begin
          lo_nxt = $signed({2'b00, p1_r}) + TS_BND_W'(1);
          hi_nxt = $signed({2'b00, p2_r}) - TS_BND_W'(1);
        end
      end
      ST_DONE: begin
        if (out_free) begin
          out_valid_nxt    = 1'b1;
          out_found_nxt    = res_found_r;
          out_position_nxt = res_pos_r;
        end
      end
      default: begin
        out_valid_nxt = out_valid_r && !out_ready;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    key_r          <= key_nxt;
    v1_r           <= v1_nxt;
    lo_r           <= lo_nxt;
    hi_r           <= hi_nxt;
    third_r        <= third_nxt;
    p1_r           <= p1_nxt;
    p2_r           <= p2_nxt;
    res_found_r    <= res_found_nxt;
    res_pos_r      <= res_pos_nxt;
    out_found_r    <= out_found_nxt;
    out_position_r <= out_position_nxt;
  end

  assign out_valid    = out_valid_r;
  assign out_found    = out_found_r;
  assign out_position = out_position_r;

endmodule

`default_nettype wire

// ===== rtl/core/ts_ram.sv =====
// ----------------------------------------------------------------------------
// ts_ram
// generic single write, single read ram with registered read data
// ----------------------------------------------------------------------------
`default_nettype none

module ts_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire
